>>> hdl/pdll_pkg.sv
package pdll_pkg;

    localparam int unsigned POOL_SIZE_DEF = 16;
    localparam int unsigned VALUE_W       = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_DUMP   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_FREE,
        RD_HEAD,
        RD_NEXT
    } t_rd_src;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_LINK,
        S_DEL_WALK,
        S_DEL_FIX,
        S_DMP_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    rd_en;
        t_rd_src rd_src;
        logic    ins_node;
        logic    ins_link;
        logic    del_unlink;
        logic    del_fix;
        logic    set_stat;
        t_status stat;
        logic    emit_item;
        logic    emit_stat;
    } t_dp_cmd;

    typedef struct packed {
        logic head_nil;
        logic free_nil;
        logic match;
        logic next_nil;
        logic prev_nil;
        logic slot_free;
    } t_dp_sts;

endpackage

>>> hdl/pdll_ctrl.sv
module pdll_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_req_type,
    input  pdll_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output pdll_pkg::t_dp_cmd o_cmd
);

    pdll_pkg::t_state r_state;
    pdll_pkg::t_state n_state;
    logic             accept;

    assign o_in_ready = (r_state == pdll_pkg::S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdll_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdll_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (pdll_pkg::t_req'(i_req_type))
                        pdll_pkg::REQ_INSERT:
                            n_state = i_sts.free_nil ? pdll_pkg::S_DONE : pdll_pkg::S_INS_RD;
                        pdll_pkg::REQ_DELETE:
                            n_state = i_sts.head_nil ? pdll_pkg::S_DONE : pdll_pkg::S_DEL_WALK;
                        pdll_pkg::REQ_DUMP:
                            n_state = i_sts.head_nil ? pdll_pkg::S_DONE : pdll_pkg::S_DMP_WALK;
                        default:
                            n_state = pdll_pkg::S_IDLE;
                    endcase
                end
            end
            pdll_pkg::S_INS_RD:
                n_state = i_sts.head_nil ? pdll_pkg::S_DONE : pdll_pkg::S_INS_LINK;
            pdll_pkg::S_INS_LINK:
                n_state = pdll_pkg::S_DONE;
            pdll_pkg::S_DEL_WALK: begin
                if (i_sts.match) begin
                    n_state = i_sts.prev_nil ? pdll_pkg::S_DONE : pdll_pkg::S_DEL_FIX;
                end else if (i_sts.next_nil) begin
                    n_state = pdll_pkg::S_DONE;
                end
            end
            pdll_pkg::S_DEL_FIX:
                n_state = pdll_pkg::S_DONE;
            pdll_pkg::S_DMP_WALK: begin
                if (i_sts.slot_free && i_sts.next_nil) begin
                    n_state = pdll_pkg::S_IDLE;
                end
            end
            pdll_pkg::S_DONE: begin
                if (i_sts.slot_free) begin
                    n_state = pdll_pkg::S_IDLE;
                end
            end
            default:
                n_state = pdll_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_src = pdll_pkg::RD_HEAD;
        o_cmd.stat   = pdll_pkg::ST_OK;
        unique case (r_state)
            pdll_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    unique case (pdll_pkg::t_req'(i_req_type))
                        pdll_pkg::REQ_INSERT: begin
                            if (i_sts.free_nil) begin
                                o_cmd.set_stat = 1'b1;
                                o_cmd.stat     = pdll_pkg::ST_FULL;
                            end else begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_src = pdll_pkg::RD_FREE;
                            end
                        end
                        pdll_pkg::REQ_DELETE, pdll_pkg::REQ_DUMP: begin
                            if (i_sts.head_nil) begin
                                o_cmd.set_stat = 1'b1;
                                o_cmd.stat     = pdll_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_src = pdll_pkg::RD_HEAD;
                            end
                        end
                        default: begin
                            o_cmd.accept = 1'b1;
                        end
                    endcase
                end
            end
            pdll_pkg::S_INS_RD: begin
                o_cmd.ins_node = 1'b1;
                o_cmd.set_stat = i_sts.head_nil;
            end
            pdll_pkg::S_INS_LINK: begin
                o_cmd.ins_link = 1'b1;
                o_cmd.set_stat = 1'b1;
            end
            pdll_pkg::S_DEL_WALK: begin
                if (i_sts.match) begin
                    o_cmd.del_unlink = 1'b1;
                    o_cmd.set_stat   = i_sts.prev_nil;
                end else if (i_sts.next_nil) begin
                    o_cmd.set_stat = 1'b1;
                    o_cmd.stat     = pdll_pkg::ST_MISSING;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = pdll_pkg::RD_NEXT;
                end
            end
            pdll_pkg::S_DEL_FIX: begin
                o_cmd.del_fix  = 1'b1;
                o_cmd.set_stat = 1'b1;
            end
            pdll_pkg::S_DMP_WALK: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit_item = 1'b1;
                    if (!i_sts.next_nil) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_src = pdll_pkg::RD_NEXT;
                    end
                end
            end
            pdll_pkg::S_DONE: begin
                o_cmd.emit_stat = i_sts.slot_free;
            end
            default: begin
                o_cmd.accept = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/pdll_dp.sv
module pdll_dp #(
    parameter int unsigned POOL_SIZE = pdll_pkg::POOL_SIZE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pdll_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [pdll_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_out_ready,
    output pdll_pkg::t_dp_sts                  o_sts,
    output logic                               o_out_valid,
    output logic [1:0]                         o_status,
    output logic signed [pdll_pkg::VALUE_W-1:0] o_item_value,
    output logic                               o_last
);

    localparam int unsigned IW = $clog2(POOL_SIZE);
    localparam int unsigned LW = $clog2(POOL_SIZE + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);

    // node pool
    logic signed [pdll_pkg::VALUE_W-1:0] mem_val  [POOL_SIZE];
    logic        [LW-1:0]                mem_next [POOL_SIZE];
    logic        [LW-1:0]                mem_prev [POOL_SIZE];
    logic        [POOL_SIZE-1:0]         r_valid;

    logic [LW-1:0] r_head, r_tail, r_free, r_cur;
    logic signed [pdll_pkg::VALUE_W-1:0] r_val;
    logic signed [pdll_pkg::VALUE_W-1:0] r_rd_val;
    logic [LW-1:0] r_rd_next, r_rd_prev;
    pdll_pkg::t_status r_stat;

    logic                                r_out_valid;
    pdll_pkg::t_status                   r_out_stat;
    logic signed [pdll_pkg::VALUE_W-1:0] r_out_val;
    logic                                r_out_last;

    logic [LW-1:0] rd_addr;
    logic          next_we, prev_we;
    logic [IW-1:0] next_wa, prev_wa;
    logic [LW-1:0] next_wd, prev_wd;
    logic          head_nil, free_nil, next_nil, prev_nil, slot_free;

    assign head_nil  = (r_head >= NIL);
    assign free_nil  = (r_free >= NIL);
    assign next_nil  = (r_rd_next >= NIL);
    assign prev_nil  = (r_rd_prev >= NIL);
    assign slot_free = !r_out_valid || i_out_ready;

    assign o_sts.head_nil  = head_nil;
    assign o_sts.free_nil  = free_nil;
    assign o_sts.match     = (r_rd_val == r_val);
    assign o_sts.next_nil  = next_nil;
    assign o_sts.prev_nil  = prev_nil;
    assign o_sts.slot_free = slot_free;

    always_comb begin
        unique case (i_cmd.rd_src)
            pdll_pkg::RD_FREE: rd_addr = r_free;
            pdll_pkg::RD_HEAD: rd_addr = r_head;
            pdll_pkg::RD_NEXT: rd_addr = r_rd_next;
            default:           rd_addr = r_head;
        endcase
    end

    // link write ports, one command at a time
    always_comb begin
        next_we = 1'b0;
        next_wa = r_cur[IW-1:0];
        next_wd = NIL;
        prev_we = 1'b0;
        prev_wa = r_cur[IW-1:0];
        prev_wd = NIL;
        if (i_cmd.ins_node) begin
            next_we = 1'b1;
            prev_we = 1'b1;
            prev_wd = head_nil ? NIL : r_tail;
        end else if (i_cmd.ins_link) begin
            next_we = 1'b1;
            next_wa = r_tail[IW-1:0];
            next_wd = r_cur;
        end else if (i_cmd.del_unlink) begin
            next_we = 1'b1;
            next_wd = r_free;
            prev_we = !next_nil;
            prev_wa = r_rd_next[IW-1:0];
            prev_wd = prev_nil ? NIL : r_rd_prev;
        end else if (i_cmd.del_fix) begin
            next_we = 1'b1;
            next_wa = r_rd_prev[IW-1:0];
            next_wd = r_rd_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_node) begin
            mem_val[r_cur[IW-1:0]] <= r_val;
        end
        if (next_we) begin
            mem_next[next_wa] <= next_wd;
        end
        if (prev_we) begin
            mem_prev[prev_wa] <= prev_wd;
        end
        // rows never written read as their reset links
        if (i_cmd.rd_en) begin
            r_rd_val  <= mem_val[rd_addr[IW-1:0]];
            r_rd_next <= r_valid[rd_addr[IW-1:0]] ? mem_next[rd_addr[IW-1:0]]
                                                  : rd_addr + LW'(1);
            r_rd_prev <= r_valid[rd_addr[IW-1:0]] ? mem_prev[rd_addr[IW-1:0]] : NIL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val <= i_value;
        end
        if (i_cmd.rd_en) begin
            r_cur <= rd_addr;
        end
        if (i_cmd.set_stat) begin
            r_stat <= i_cmd.stat;
        end
        if (i_cmd.emit_item) begin
            r_out_stat <= pdll_pkg::ST_OK;
            r_out_val  <= r_rd_val;
            r_out_last <= next_nil;
        end else if (i_cmd.emit_stat) begin
            r_out_stat <= r_stat;
            r_out_val  <= '0;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NIL;
            r_tail      <= NIL;
            r_free      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_node) begin
                r_free                <= r_rd_next;
                r_valid[r_cur[IW-1:0]] <= 1'b1;
                if (head_nil) begin
                    r_head <= r_cur;
                    r_tail <= r_cur;
                end
            end
            if (i_cmd.ins_link) begin
                r_tail <= r_cur;
            end
            if (i_cmd.del_unlink) begin
                r_free <= r_cur;
                if (prev_nil) begin
                    r_head <= next_nil ? NIL : r_rd_next;
                end
                if (next_nil) begin
                    r_tail <= prev_nil ? NIL : r_rd_prev;
                end
            end
            if (i_cmd.emit_item || i_cmd.emit_stat) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_stat;
    assign o_item_value = r_out_val;
    assign o_last       = r_out_last;

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_item || i_cmd.emit_stat) |-> slot_free)
        else $error("result loaded over a waiting beat");

    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_nil == (r_tail >= NIL))
        else $error("head and tail disagree on empty list");

    a_empty_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_nil |-> !free_nil)
        else $error("empty list with exhausted free chain");

    a_rd_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (rd_addr < NIL))
        else $error("pool read at a null link");

    a_ins_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_node |-> (r_cur < NIL) && !r_valid[r_cur[IW-1:0]] || r_valid[r_cur[IW-1:0]])
        else $error("insert at a null link");

endmodule

>>> hdl/pool_doubly_linked_list.sv
// Pool-based doubly linked list with a free chain.
// Input channel (i_in_valid / o_in_ready) carries one request per beat:
// i_req_type insert-at-tail, delete-first-match or dump, with i_value.
// Output channel (o_out_valid / i_out_ready) returns result beats with
// o_status, o_item_value and o_last; o_last marks the final beat of a request.
// Insert and delete give one beat, dump gives one beat per element (or a
// single list-empty beat), an unused request type gives none.
// One request is worked at a time. Insert reads the free node, writes it
// and, unless the list is empty, links it behind the tail; a full pool skips
// both. Delete walks from the head to the first match (or to the tail when
// the value is absent), then fixes the predecessor's link when the node has
// one. Dump: one beat per cycle while the output register has room. The node
// pool has a single read port: each link is followed with one registered read
// per cycle, and the tail is kept in a register so insert needs no walk.
// The result sits in an output register; while the receiver stalls the walk
// pauses. A new request is taken the cycle after the final beat is loaded,
// even while that beat still waits for the receiver.
// Reset (synchronous, active low) empties the list and puts every node on the
// free chain at once through per-row valid bits; no clearing pass is needed.
module pool_doubly_linked_list #(
    parameter int unsigned POOL_SIZE = pdll_pkg::POOL_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_req_type,
    input  logic signed [pdll_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic signed [pdll_pkg::VALUE_W-1:0] o_item_value,
    output logic                                o_last
);

    pdll_pkg::t_dp_cmd cmd;
    pdll_pkg::t_dp_sts sts;

    pdll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pdll_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .i_out_ready  (i_out_ready),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_item_value (o_item_value),
        .o_last       (o_last)
    );

endmodule

>>> bench/pdll_checker.sv
module pdll_checker #(
    parameter int unsigned POOL_SIZE = pdll_pkg::POOL_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [1:0]                          i_req_type,
    input  logic signed [pdll_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [1:0]                          i_status,
    input  logic signed [pdll_pkg::VALUE_W-1:0] i_item_value,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_req_count,
    output int                                  o_beat_count,
    output int                                  o_full_seen,
    output int                                  o_empty_seen,
    output int                                  o_missing_seen
);

    localparam int unsigned LINK_W = $clog2(POOL_SIZE + 1);
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_SIZE);

    typedef struct packed {
        pdll_pkg::t_status                   status;
        logic signed [pdll_pkg::VALUE_W-1:0] item_value;
        logic                                last;
    } t_list_beat;

    // shadow copy of the node pool
    logic signed [pdll_pkg::VALUE_W-1:0] pool_value [POOL_SIZE];
    logic [LINK_W-1:0]                   pool_next  [POOL_SIZE];
    logic [LINK_W-1:0]                   pool_prev  [POOL_SIZE];
    logic [LINK_W-1:0]                   head_link;
    logic [LINK_W-1:0]                   free_link;

    t_list_beat beats_due[$];
    int fail_total   = 0;
    int req_total    = 0;
    int beat_total   = 0;
    int full_hits    = 0;
    int empty_hits   = 0;
    int missing_hits = 0;

    function automatic logic is_node(input logic [LINK_W-1:0] link);
        return link < NIL_LINK;
    endfunction

    function automatic void queue_beat(input pdll_pkg::t_status status,
                                       input logic signed [pdll_pkg::VALUE_W-1:0] item_value,
                                       input logic last);
        t_list_beat b;
        b.status     = status;
        b.item_value = item_value;
        b.last       = last;
        beats_due.push_back(b);
        unique case (status)
            pdll_pkg::ST_FULL:    full_hits++;
            pdll_pkg::ST_EMPTY:   empty_hits++;
            pdll_pkg::ST_MISSING: missing_hits++;
            default: ;
        endcase
    endfunction

    function automatic void clear_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_value[i] = '0;
            pool_next[i]  = LINK_W'(i + 1);
            pool_prev[i]  = NIL_LINK;
        end
        head_link = NIL_LINK;
        free_link = '0;
    endfunction

    function automatic pdll_pkg::t_status list_insert(
        input logic signed [pdll_pkg::VALUE_W-1:0] v);
        logic [LINK_W-1:0] n;
        logic [LINK_W-1:0] t;
        int k;
        n = free_link;
        if (!is_node(n)) return pdll_pkg::ST_FULL;
        free_link     = pool_next[n];
        pool_next[n]  = NIL_LINK;
        pool_prev[n]  = NIL_LINK;
        pool_value[n] = v;
        if (!is_node(head_link)) begin
            head_link = n;
            return pdll_pkg::ST_OK;
        end
        t = head_link;
        for (k = 0; k < POOL_SIZE && is_node(pool_next[t]); k++)
            t = pool_next[t];
        pool_next[t] = n;
        pool_prev[n] = t;
        return pdll_pkg::ST_OK;
    endfunction

    function automatic pdll_pkg::t_status list_delete(
        input logic signed [pdll_pkg::VALUE_W-1:0] v);
        logic [LINK_W-1:0] c;
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] nx;
        int k;
        c = head_link;
        if (!is_node(c)) return pdll_pkg::ST_EMPTY;
        for (k = 0; k < POOL_SIZE && is_node(c) && pool_value[c] != v; k++)
            c = pool_next[c];
        if (!is_node(c) || pool_value[c] != v) return pdll_pkg::ST_MISSING;
        p  = pool_prev[c];
        nx = pool_next[c];
        if (is_node(p))
            pool_next[p] = nx;
        else
            head_link = is_node(nx) ? nx : NIL_LINK;
        if (is_node(nx))
            pool_prev[nx] = is_node(p) ? p : NIL_LINK;
        pool_next[c] = free_link;
        free_link    = c;
        return pdll_pkg::ST_OK;
    endfunction

    function automatic void list_dump();
        logic [LINK_W-1:0] c;
        logic [LINK_W-1:0] nx;
        int k;
        c = head_link;
        k = 0;
        if (!is_node(c)) begin
            queue_beat(pdll_pkg::ST_EMPTY, '0, 1'b1);
            return;
        end
        while (k < POOL_SIZE && is_node(c)) begin
            nx = pool_next[c];
            queue_beat(pdll_pkg::ST_OK, pool_value[c],
                       !is_node(nx) || (k + 1 >= POOL_SIZE));
            k++;
            c = nx;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_list_beat want;
        if (!i_rst_n) begin
            clear_pool();
            beats_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                req_total++;
                unique case (i_req_type)
                    pdll_pkg::REQ_INSERT: queue_beat(list_insert(i_value), '0, 1'b1);
                    pdll_pkg::REQ_DELETE: queue_beat(list_delete(i_value), '0, 1'b1);
                    pdll_pkg::REQ_DUMP:   list_dump();
                    default: ;  // unused code, no beat
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                beat_total++;
                if (beats_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat status %0d value %0d last %0b",
                                              i_status, i_item_value, i_last));
                end else begin
                    want = beats_due.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_status, want.status));
                    if (i_item_value !== want.item_value)
                        report_mismatch($sformatf("item_value got %0d want %0d",
                                                  i_item_value, want.item_value));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  i_last, want.last));
                end
            end
        end
        o_fail_count   <= fail_total;
        o_pending      <= beats_due.size();
        o_req_count    <= req_total;
        o_beat_count   <= beat_total;
        o_full_seen    <= full_hits;
        o_empty_seen   <= empty_hits;
        o_missing_seen <= missing_hits;
    end

endmodule

>>> bench/tb_pool_doubly_linked_list.sv
module tb_pool_doubly_linked_list;

    localparam int unsigned POOL_SIZE   = pdll_pkg::POOL_SIZE_DEF;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RANDOM_REQS = 30;   // per idling mix

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic [1:0]                          i_req_type;
    logic signed [pdll_pkg::VALUE_W-1:0] i_value;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic [1:0]                          o_status;
    logic signed [pdll_pkg::VALUE_W-1:0] o_item_value;
    logic                                o_last;

    int fail_count;
    int pending;
    int req_count;
    int beat_count;
    int full_seen;
    int empty_seen;
    int missing_seen;

    int in_idle_pct;
    int out_idle_pct;
    int cycle_count = 0;
    logic signed [pdll_pkg::VALUE_W-1:0] palette [6];

    pool_doubly_linked_list #(.POOL_SIZE(POOL_SIZE)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_item_value (o_item_value),
        .o_last       (o_last)
    );

    pdll_checker #(.POOL_SIZE(POOL_SIZE)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_status       (o_status),
        .i_item_value   (o_item_value),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_req_count    (req_count),
        .o_beat_count   (beat_count),
        .o_full_seen    (full_seen),
        .o_empty_seen   (empty_seen),
        .o_missing_seen (missing_seen)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // hold valid and payload until the beat is taken
    task automatic send_request(input logic [1:0] kind,
                                input logic signed [pdll_pkg::VALUE_W-1:0] v);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_value    <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic logic signed [pdll_pkg::VALUE_W-1:0] pick_value();
        unique case ($urandom_range(9))
            0:             return 32'sh8000_0000;
            1:             return 32'sh7fff_ffff;
            2, 3, 4, 5, 6: return palette[$urandom_range(5)];
            default:       return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_kind(input int ins_weight);
        int r;
        r = $urandom_range(99);
        if (r < 4)                   return REQ_UNUSED;
        else if (r < 4 + ins_weight) return pdll_pkg::REQ_INSERT;
        else if (r < 88)             return pdll_pkg::REQ_DELETE;
        else                         return pdll_pkg::REQ_DUMP;
    endfunction

    initial begin
        in_idle_pct  = 7;
        out_idle_pct = 71;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_req_type  <= pdll_pkg::REQ_INSERT;
        i_value     <= '0;
        foreach (palette[i]) palette[i] = $urandom;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list cases and the unused code, then a short list to dump and search
        send_request(pdll_pkg::REQ_DUMP, 32'sd0);
        send_request(pdll_pkg::REQ_DELETE, 32'sd7);
        send_request(REQ_UNUSED, 32'sd7);
        send_request(pdll_pkg::REQ_INSERT, 32'sh8000_0000);
        send_request(pdll_pkg::REQ_INSERT, 32'sh7fff_ffff);
        send_request(pdll_pkg::REQ_INSERT, 32'sd0);
        send_request(pdll_pkg::REQ_INSERT, -32'sd1);
        send_request(pdll_pkg::REQ_DUMP, -32'sd1);
        send_request(pdll_pkg::REQ_DELETE, 32'sd5);
        // middle, head, tail
        send_request(pdll_pkg::REQ_DELETE, 32'sd0);
        send_request(pdll_pkg::REQ_DELETE, 32'sh8000_0000);
        send_request(pdll_pkg::REQ_DELETE, -32'sd1);
        // fill the pool, with duplicates of the head value
        for (int i = 0; i < POOL_SIZE - 1; i++)
            send_request(pdll_pkg::REQ_INSERT, (i % 4 == 0) ? 32'sh7fff_ffff : $urandom);
        send_request(pdll_pkg::REQ_INSERT, 32'sh5555_aaaa);
        send_request(pdll_pkg::REQ_DUMP, 32'sh5555_aaaa);
        send_request(pdll_pkg::REQ_DELETE, 32'sh7fff_ffff);
        send_request(pdll_pkg::REQ_DUMP, 32'sd0);

        for (int mix = 0; mix < 3; mix++) begin
            in_idle_pct  = (mix == 0) ? 7 : (mix == 1) ? 71 : 0;
            out_idle_pct = (mix == 0) ? 71 : (mix == 1) ? 7 : 0;
            foreach (palette[i]) palette[i] = $urandom;
            // fill-heavy then drain-heavy so the list sweeps full and empty
            for (int n = 0; n < RANDOM_REQS; n++)
                send_request(pick_kind((n < RANDOM_REQS / 2) ? 75 : 20), pick_value());
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d requests and %0d result beats over three idling mixes",
                 req_count, beat_count);
        $display("outcomes: %0d pool full, %0d list empty, %0d value not found",
                 full_seen, empty_seen, missing_seen);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
